@@ hdl/rsi_pkg.sv @@
`timescale 1ns / 1ps
// Package for the ray-sphere intersection core: status codes, widths and
// the payload types of the square-root and divider pipelines. No dependencies.
package rsi_pkg;

  localparam logic [1:0] ST_MISS    = 2'd0;
  localparam logic [1:0] ST_TANGENT = 2'd1;
  localparam logic [1:0] ST_TWO     = 2'd2;
  localparam logic [1:0] ST_ZERODIR = 2'd3;

  localparam int unsigned LimbW   = 23;   // partial product limb width
  localparam int unsigned NumLimb = 3;
  localparam int unsigned DiscW   = 131;  // non-negative discriminant bits
  localparam int unsigned RootW   = 66;
  localparam int unsigned NumW    = 83;   // |(-b - root)| << 16
  localparam int unsigned DistW   = 48;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [65:0] b;
    logic [63:0]        a;
    logic [DiscW-1:0]   rem;
    logic [RootW-1:0]   root;
  } sq_t;

  typedef struct packed {
    logic [1:0]      status;
    logic            nneg;
    logic [63:0]     a;
    logic [NumW-1:0] num;
    logic [63:0]     rem;
    logic [NumW-1:0] quo;
  } dv_t;

endpackage

@@ hdl/rsi_if.sv @@
`timescale 1ns / 1ps
// Request and result channel interfaces of the ray-sphere intersection core.
// Depends on nothing; payload widths follow the fixed field widths.
interface rsi_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] origin_x;
  logic [31:0] origin_y;
  logic [31:0] origin_z;
  logic [31:0] dir_x;
  logic [31:0] dir_y;
  logic [31:0] dir_z;
  logic [31:0] center_x;
  logic [31:0] center_y;
  logic [31:0] center_z;
  logic [30:0] radius;
  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  center_x, center_y, center_z, radius, input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                center_x, center_y, center_z, radius, output ready);
endinterface

interface rsi_rsp_if;
  logic        valid;
  logic        ready;
  logic [47:0] hit_distance;
  logic [1:0]  status;
  modport source (output valid, hit_distance, status, input ready);
  modport sink (input valid, hit_distance, status, output ready);
endinterface

@@ hdl/ray_sphere_intersect_core.sv @@
`timescale 1ns / 1ps
// Ray-sphere intersection core: fully pipelined, one request per cycle while the
// output is not stalled. It has six setup stages, 66 square-root stages (one root bit
// each), one stage to form the numerator, 83 divider stages (one quotient bit
// each) and the output register. A stall freezes every stage at once.
// Reset clears only the valid bits; no clearing pass is needed.
module ray_sphere_intersect_core #(
  parameter int COORD_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rsi_req_if.sink   req_i,
  rsi_rsp_if.source rsp_o
);

  localparam int CW = (COORD_WIDTH > 32) ? 32 : ((COORD_WIDTH < 2) ? 2 : COORD_WIDTH);
  localparam int LW = rsi_pkg::LimbW;
  localparam int NL = rsi_pkg::NumLimb;
  localparam int NSQ = rsi_pkg::RootW;
  localparam int NDV = rsi_pkg::NumW;

  logic en;
  logic out_valid_q;
  assign en = !out_valid_q || rsp_o.ready;
  assign req_i.ready = en;

  // Stage 1: operand selection and o - c.
  logic               v1_q;
  logic signed [31:0] d1_q [3];
  logic signed [32:0] e1_q [3];
  logic [31:0]        ea1_q [3];
  logic [30:0]        r1_q;
  logic signed [31:0] d1_d [3];
  logic signed [32:0] e1_d [3];
  logic [31:0]        ea1_d [3];
  logic [30:0]        r1_d;
  logic [31:0]        oin [3];
  logic [31:0]        din [3];
  logic [31:0]        cin [3];

  assign oin = '{req_i.origin_x, req_i.origin_y, req_i.origin_z};
  assign din = '{req_i.dir_x, req_i.dir_y, req_i.dir_z};
  assign cin = '{req_i.center_x, req_i.center_y, req_i.center_z};

  always_comb begin
    logic signed [31:0] o;
    logic signed [31:0] c;
    for (int i = 0; i < 3; i++) begin
      o        = 32'(signed'(oin[i][CW-1:0]));
      c        = 32'(signed'(cin[i][CW-1:0]));
      d1_d[i]  = 32'(signed'(din[i][CW-1:0]));
      e1_d[i]  = 33'(o) - 33'(c);
      ea1_d[i] = e1_d[i][32] ? 32'(-e1_d[i]) : e1_d[i][31:0];
    end
    r1_d = 31'(req_i.radius[CW-2:0]);
  end

  // Stage 2: element products.
  logic               v2_q;
  logic [62:0]        dd2_q [3];
  logic signed [64:0] de2_q [3];
  logic [63:0]        ee2_q [3];
  logic [61:0]        rr2_q;
  logic signed [63:0] dd2_d [3];
  logic signed [64:0] de2_d [3];
  logic [63:0]        ee2_d [3];
  logic [61:0]        rr2_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dd2_d[i] = d1_q[i] * d1_q[i];
      de2_d[i] = d1_q[i] * e1_q[i];
      ee2_d[i] = ea1_q[i] * ea1_q[i];
    end
    rr2_d = r1_q * r1_q;
  end

  // Stage 3: A, half-B and C.
  logic               v3_q;
  logic [63:0]        a3_q, a3_d;
  logic signed [65:0] b3_q, b3_d;
  logic signed [66:0] c3_q, c3_d;

  always_comb begin
    a3_d = 64'(dd2_q[0]) + 64'(dd2_q[1]) + 64'(dd2_q[2]);
    b3_d = 66'(de2_q[0]) + 66'(de2_q[1]) + 66'(de2_q[2]);
    c3_d = 67'(ee2_q[0]) + 67'(ee2_q[1]) + 67'(ee2_q[2]) - 67'(rr2_q);
  end

  // Stage 4: limb partial products of b*b and A*|C|.
  logic               v4_q;
  logic [2*LW-1:0]    pb4_q [NL][NL];
  logic [2*LW-1:0]    pa4_q [NL][NL];
  logic [2*LW-1:0]    pb4_d [NL][NL];
  logic [2*LW-1:0]    pa4_d [NL][NL];
  logic [63:0]        a4_q;
  logic signed [65:0] b4_q;
  logic               cneg4_q;

  always_comb begin
    logic [NL*LW-1:0] bm;
    logic [NL*LW-1:0] cm;
    logic [NL*LW-1:0] am;
    bm = (NL*LW)'(b3_q[65] ? -b3_q : b3_q);
    cm = (NL*LW)'(c3_q[66] ? -c3_q : c3_q);
    am = (NL*LW)'(a3_q);
    for (int i = 0; i < NL; i++) begin
      for (int j = 0; j < NL; j++) begin
        pb4_d[i][j] = bm[i*LW +: LW] * bm[j*LW +: LW];
        pa4_d[i][j] = am[i*LW +: LW] * cm[j*LW +: LW];
      end
    end
  end

  // Stage 5: sum the partial products.
  logic               v5_q;
  logic [131:0]       bb5_q, bb5_d;
  logic [131:0]       ac5_q, ac5_d;
  logic [63:0]        a5_q;
  logic signed [65:0] b5_q;
  logic               cneg5_q;

  always_comb begin
    bb5_d = '0;
    ac5_d = '0;
    for (int i = 0; i < NL; i++) begin
      for (int j = 0; j < NL; j++) begin
        bb5_d = bb5_d + (132'(pb4_q[i][j]) << (LW*(i+j)));
        ac5_d = ac5_d + (132'(pa4_q[i][j]) << (LW*(i+j)));
      end
    end
  end

  // Stage 6: quarter discriminant and status.
  rsi_pkg::sq_t sq_q [NSQ+1];
  logic         sqv_q [NSQ+1];
  rsi_pkg::sq_t sq0_d;

  always_comb begin
    logic signed [132:0] disc;
    disc = cneg5_q ? (133'(bb5_q) + 133'(ac5_q)) : (133'(bb5_q) - 133'(ac5_q));
    sq0_d.b    = b5_q;
    sq0_d.a    = a5_q;
    sq0_d.rem  = disc[rsi_pkg::DiscW-1:0];
    sq0_d.root = '0;
    if (a5_q == '0) begin
      sq0_d.status = rsi_pkg::ST_ZERODIR;
    end else if (disc[132]) begin
      sq0_d.status = rsi_pkg::ST_MISS;
    end else if (disc == '0) begin
      sq0_d.status = rsi_pkg::ST_TANGENT;
    end else begin
      sq0_d.status = rsi_pkg::ST_TWO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      v4_q     <= 1'b0;
      v5_q     <= 1'b0;
      sqv_q[0] <= 1'b0;
    end else if (en) begin
      v1_q     <= req_i.valid;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      v4_q     <= v3_q;
      v5_q     <= v4_q;
      sqv_q[0] <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_q    <= d1_d;
      e1_q    <= e1_d;
      ea1_q   <= ea1_d;
      r1_q    <= r1_d;
      for (int i = 0; i < 3; i++) begin
        dd2_q[i] <= dd2_d[i][62:0];
      end
      de2_q   <= de2_d;
      ee2_q   <= ee2_d;
      rr2_q   <= rr2_d;
      a3_q    <= a3_d;
      b3_q    <= b3_d;
      c3_q    <= c3_d;
      pb4_q   <= pb4_d;
      pa4_q   <= pa4_d;
      a4_q    <= a3_q;
      b4_q    <= b3_q;
      cneg4_q <= c3_q[66];
      bb5_q   <= bb5_d;
      ac5_q   <= ac5_d;
      a5_q    <= a4_q;
      b5_q    <= b4_q;
      cneg5_q <= cneg4_q;
      sq_q[0] <= sq0_d;
    end
  end

  // Square root, one root bit per stage from the top down. The remainder
  // holds D - root^2; the trial is (root << (k+1)) + 4^k.
  for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
    localparam int K = NSQ - 1 - g;
    rsi_pkg::sq_t nxt;

    always_comb begin
      logic [133:0] trial;
      logic         ge;
      trial = (134'(sq_q[g].root) << (K + 1)) + (134'(1) << (2 * K));
      ge    = 134'(sq_q[g].rem) >= trial;
      nxt   = sq_q[g];
      if (ge) begin
        nxt.rem  = sq_q[g].rem - trial[rsi_pkg::DiscW-1:0];
        nxt.root = sq_q[g].root | (NSQ'(1) << K);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sqv_q[g+1] <= 1'b0;
      end else if (en) begin
        sqv_q[g+1] <= sqv_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[g+1] <= nxt;
      end
    end
  end

  // Numerator: (-b - root) scaled by 2^16, split into sign and magnitude.
  rsi_pkg::dv_t dv_q [NDV+1];
  logic         dvv_q [NDV+1];
  rsi_pkg::dv_t dv0_d;

  always_comb begin
    logic signed [67:0] n;
    n = -68'(sq_q[NSQ].b) - 68'(sq_q[NSQ].root);
    dv0_d.status = sq_q[NSQ].status;
    dv0_d.nneg   = n[67];
    dv0_d.a      = sq_q[NSQ].a;
    dv0_d.num    = {67'(n[67] ? -n : n), 16'h0000};
    dv0_d.rem    = '0;
    dv0_d.quo    = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvv_q[0] <= 1'b0;
    end else if (en) begin
      dvv_q[0] <= sqv_q[NSQ];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_q[0] <= dv0_d;
    end
  end

  // Restoring division of the magnitude by A, one quotient bit per stage.
  for (genvar g = 0; g < NDV; g++) begin : g_div
    localparam int K = NDV - 1 - g;
    rsi_pkg::dv_t nxt;

    always_comb begin
      logic [64:0] part;
      logic [64:0] diff;
      part = {dv_q[g].rem, dv_q[g].num[K]};
      diff = part - 65'(dv_q[g].a);
      nxt  = dv_q[g];
      if (part >= 65'(dv_q[g].a)) begin
        nxt.rem = diff[63:0];
        nxt.quo = dv_q[g].quo | (NDV'(1) << K);
      end else begin
        nxt.rem = part[63:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dvv_q[g+1] <= 1'b0;
      end else if (en) begin
        dvv_q[g+1] <= dvv_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[g+1] <= nxt;
      end
    end
  end

  // Output: floor toward minus infinity, saturation, miss and zero direction.
  localparam logic [83:0] MaxPos = 84'((84'(1) << (rsi_pkg::DistW - 1)) - 84'(1));
  localparam logic [83:0] MaxNeg = 84'(1) << (rsi_pkg::DistW - 1);

  rsi_pkg::dv_t fin;
  logic [47:0]  dist_d, dist_q;
  logic [1:0]   status_q;

  assign fin = dv_q[NDV];

  always_comb begin
    logic [83:0] qsum;
    qsum = 84'(fin.quo) + 84'(fin.nneg && (fin.rem != '0));
    if (fin.status == rsi_pkg::ST_MISS || fin.status == rsi_pkg::ST_ZERODIR) begin
      dist_d = '0;
    end else if (fin.nneg) begin
      dist_d = (qsum > MaxNeg) ? MaxNeg[47:0] : 48'(-qsum);
    end else begin
      dist_d = (qsum > MaxPos) ? MaxPos[47:0] : qsum[47:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dvv_q[NDV];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q   <= dist_d;
      status_q <= fin.status;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.hit_distance = dist_q;
  assign rsp_o.status       = status_q;

endmodule

@@ bench/tb_ray_sphere_intersect_core.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for ray_sphere_intersect_core: random and directed
// ray-sphere pairs, results checked against an exact integer predictor.
// Depends on ray_sphere_intersect_core, rsi_pkg, rsi_req_if and rsi_rsp_if from the RTL.
module tb_ray_sphere_intersect_core;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned DrainWait  = 400;
  localparam logic signed [191:0] DistMax = (192'sd1 <<< 47) - 1;
  localparam logic signed [191:0] DistMin = -(192'sd1 <<< 47);

  typedef struct {
    logic [2:0][31:0] org;
    logic [2:0][31:0] dir;
    logic [2:0][31:0] ctr;
    logic [30:0]      rad;
    bit               drain;  // hold the request back until all results are in
  } ray_req_t;

  typedef struct {
    logic [47:0] hit_dist;
    logic [1:0]  status;
  } hit_t;

  logic clk_i;
  logic rst_ni;
  rsi_req_if req();
  rsi_rsp_if rsp();

  ray_sphere_intersect_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  ray_req_t    pending_rays[$];
  hit_t        expected_hits[$];
  int unsigned errors;
  int unsigned hits_checked;
  int unsigned status_seen[4];
  int unsigned cycles;
  bit          quiet_mode;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Exact nearer-root computation in wide signed integers.
  function automatic hit_t trace_sphere(ray_req_t r);
    logic signed [191:0] a_q, hb, c_q, disc, root, rest, bit_v, num, quo;
    logic signed [191:0] oo, cc, dv, e;
    hit_t h;
    a_q = 0;
    hb  = 0;
    c_q = 0;
    for (int i = 0; i < 3; i++) begin
      oo = $signed(r.org[i]);
      cc = $signed(r.ctr[i]);
      dv = $signed(r.dir[i]);
      e  = oo - cc;
      a_q = a_q + dv * dv;
      hb  = hb + dv * e;
      c_q = c_q + e * e;
    end
    c_q = c_q - $signed({161'b0, r.rad}) * $signed({161'b0, r.rad});
    h.hit_dist = '0;
    if (a_q == 0) begin
      h.status = rsi_pkg::ST_ZERODIR;
      return h;
    end
    disc = hb * hb - a_q * c_q;
    if (disc < 0) begin
      h.status = rsi_pkg::ST_MISS;
      return h;
    end
    h.status = (disc == 0) ? rsi_pkg::ST_TANGENT : rsi_pkg::ST_TWO;
    rest  = disc;
    root  = 0;
    bit_v = 192'sd1 <<< 190;
    while (bit_v > rest) bit_v = bit_v >>> 2;
    while (bit_v != 0) begin
      if (rest >= root + bit_v) begin
        rest = rest - (root + bit_v);
        root = (root >>> 1) + bit_v;
      end else begin
        root = root >>> 1;
      end
      bit_v = bit_v >>> 2;
    end
    num = (-hb - root) <<< 16;
    quo = num / a_q;
    if (num < 0 && quo * a_q != num) quo = quo - 1;
    if (quo > DistMax) quo = DistMax;
    else if (quo < DistMin) quo = DistMin;
    h.hit_dist = quo[47:0];
    return h;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned p;
    if (quiet_mode) return 0;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(150, 20);
  endfunction

  function automatic logic [31:0] q16(int v);
    return v <<< 16;
  endfunction

  function automatic ray_req_t make_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                        int cx, int cy, int cz, int r);
    ray_req_t t;
    t.org = {q16(oz), q16(oy), q16(ox)};
    t.dir = {q16(dz), q16(dy), q16(dx)};
    t.ctr = {q16(cz), q16(cy), q16(cx)};
    t.rad = 31'(q16(r));
    t.drain = 1'b0;
    return t;
  endfunction

  // Mostly rays aimed near the sphere so hits dominate; the rest are raw bits.
  function automatic ray_req_t random_ray();
    ray_req_t t;
    int k, oi, di;
    if ($urandom_range(3) == 0) begin
      for (int i = 0; i < 3; i++) begin
        t.org[i] = $urandom;
        t.dir[i] = $urandom;
        t.ctr[i] = $urandom;
      end
      t.rad = 31'($urandom);
    end else begin
      k = $urandom_range(15);
      for (int i = 0; i < 3; i++) begin
        oi = $urandom_range(1 << 25) - (1 << 24);
        di = $urandom_range(1 << 19) - (1 << 18);
        t.org[i] = oi;
        t.dir[i] = di;
        t.ctr[i] = oi + di * k + ($urandom_range(1 << 17) - (1 << 16));
      end
      t.rad = 31'($urandom_range(1 << 22));
    end
    t.drain = 1'b0;
    return t;
  endfunction

  // Request driver: gaps between requests, predicts each accepted request.
  int unsigned gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req.valid <= 1'b0;
      gap_left  <= 0;
    end else begin
      if (req.valid && req.ready) begin
        expected_hits.push_back(trace_sphere('{org: {req.origin_z, req.origin_y,
            req.origin_x}, dir: {req.dir_z, req.dir_y, req.dir_x}, ctr: {req.center_z,
            req.center_y, req.center_x}, rad: req.radius, drain: 1'b0}));
      end
      if (!req.valid || req.ready) begin
        if (gap_left != 0) begin
          req.valid <= 1'b0;
          gap_left  <= gap_left - 1;
        end else if (pending_rays.size() != 0 &&
                     !(pending_rays[0].drain && expected_hits.size() != 0)) begin
          ray_req_t t;
          t = pending_rays.pop_front();
          req.valid    <= 1'b1;
          req.origin_x <= t.org[0];
          req.origin_y <= t.org[1];
          req.origin_z <= t.org[2];
          req.dir_x    <= t.dir[0];
          req.dir_y    <= t.dir[1];
          req.dir_z    <= t.dir[2];
          req.center_x <= t.ctr[0];
          req.center_y <= t.ctr[1];
          req.center_z <= t.ctr[2];
          req.radius   <= t.rad;
          gap_left     <= gap_len();
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  int unsigned stall_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp.ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_hits.size() == 0) begin
          $display("%0t: unexpected result hit_distance=%h status=%0d", $time,
                   rsp.hit_distance, rsp.status);
          errors++;
        end else begin
          hit_t x;
          x = expected_hits.pop_front();
          hits_checked++;
          status_seen[x.status]++;
          if (rsp.hit_distance !== x.hit_dist) begin
            $display("%0t: hit_distance expected %h actual %h", $time, x.hit_dist,
                     rsp.hit_distance);
            errors++;
          end
          if (rsp.status !== x.status) begin
            $display("%0t: status expected %0d actual %0d", $time, x.status, rsp.status);
            errors++;
          end
        end
      end
      if (stall_left != 0) begin
        rsp.ready  <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        rsp.ready  <= 1'b1;
        stall_left <= gap_len();
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    ray_req_t t;
    errors     = 0;
    cycles     = 0;
    quiet_mode = 1'b0;
    hits_checked = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    req.valid    = 1'b0;
    req.origin_x = '0;
    req.origin_y = '0;
    req.origin_z = '0;
    req.dir_x    = '0;
    req.dir_y    = '0;
    req.dir_z    = '0;
    req.center_x = '0;
    req.center_y = '0;
    req.center_z = '0;
    req.radius   = '0;
    rsp.ready    = 1'b0;
    rst_ni       = 1'b0;

    // Directed requests: zero direction, tangent, two roots, miss, origin
    // inside the sphere (negative root), saturation and field extremes.
    pending_rays.push_back(make_ray(0, 0, 0, 0, 0, 0, 5, 0, 0, 1));
    pending_rays.push_back(make_ray(0, 0, 0, 1, 0, 0, 5, 1, 0, 1));
    pending_rays.push_back(make_ray(0, 0, 0, 1, 0, 0, 5, 0, 0, 1));
    pending_rays.push_back(make_ray(0, 0, 0, 1, 0, 0, 5, 3, 0, 1));
    pending_rays.push_back(make_ray(0, 0, 0, 0, 1, 0, 0, 0, 0, 2));
    pending_rays.push_back(make_ray(0, 0, 0, -3, 0, 0, -9, 0, 0, 2));
    pending_rays.push_back(make_ray(0, 0, 0, 1, 0, 0, 0, 0, 0, 0));
    t = make_ray(-30000, 0, 0, 0, 0, 0, 30000, 0, 0, 1);
    t.dir[0] = 32'd1;
    pending_rays.push_back(t);
    t.dir[0] = 32'hffff_ffff;
    pending_rays.push_back(t);
    t.org = {3{32'h7fff_ffff}};
    t.dir = {3{32'h8000_0000}};
    t.ctr = {3{32'h8000_0000}};
    t.rad = '1;
    pending_rays.push_back(t);
    t.org = {3{32'h8000_0000}};
    t.dir = {3{32'h7fff_ffff}};
    t.ctr = {3{32'h7fff_ffff}};
    pending_rays.push_back(t);
    t.dir = {3{32'h8000_0000}};
    t.rad = '0;
    pending_rays.push_back(t);
    t.org = '0;
    t.ctr = '0;
    t.dir = {32'd0, 32'd0, 32'h8000_0000};
    t.rad = '1;
    pending_rays.push_back(t);
    t.dir = {32'd0, 32'd0, 32'd1};
    pending_rays.push_back(t);
    t.drain = 1'b1;
    t.dir = {32'd0, 32'd1, 32'd0};
    pending_rays.push_back(t);

    for (int n = 0; n < 1200; n++) begin
      t = random_ray();
      if (n == 600) t.drain = 1'b1;
      pending_rays.push_back(t);
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Alternate between stretches with and without idle cycles.
    while (pending_rays.size() != 0) begin
      @(posedge clk_i);
      if ($urandom_range(299) == 0) quiet_mode <= ~quiet_mode;
    end
    quiet_mode <= 1'b0;
    while (expected_hits.size() != 0 || req.valid) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Checked %0d results: %0d miss, %0d tangent, %0d two-root,",
             hits_checked, status_seen[rsi_pkg::ST_MISS],
             status_seen[rsi_pkg::ST_TANGENT], status_seen[rsi_pkg::ST_TWO]);
    $display("and %0d zero-direction, under random gaps and back-pressure.",
             status_seen[rsi_pkg::ST_ZERODIR]);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
